// File: hdl/swm_pkg.sv
`timescale 1ns / 1ps
// Package for the stack with middle access: sizes, opcodes, status codes
// and the control bundle broadcast to every storage cell. No dependencies.
package swm_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OCC_W  = 6;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_MID  = 2'd2,
    OP_DEL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             do_push;
    logic             do_del;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] rd_idx;
  } cell_ctrl_t;

endpackage

// File: hdl/swm_cell.sv
`timescale 1ns / 1ps
// One storage cell of the stack: holds a single entry and takes its
// upper neighbor's entry when the middle is deleted. Depends on swm_pkg.
module swm_cell (
  input  logic                                clk,
  input  logic [swm_pkg::IDX_W-1:0]           cell_idx,
  input  swm_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [swm_pkg::DATA_W-1:0]   push_value,
  input  logic signed [swm_pkg::DATA_W-1:0]   upper_value,
  output logic signed [swm_pkg::DATA_W-1:0]   entry_value,
  output logic signed [swm_pkg::DATA_W-1:0]   rd_value
);

  logic signed [swm_pkg::DATA_W-1:0] entry_r;
  logic signed [swm_pkg::DATA_W-1:0] entry_nxt;
  logic [swm_pkg::CNT_W-1:0]         idx;
  logic                              push_here;
  logic                              shift_here;

  assign idx = swm_pkg::CNT_W'(cell_idx);

  // Every cell from the middle up to, but not including, the current top moves down.
  assign push_here  = ctrl.do_push && (ctrl.count == idx);
  assign shift_here = ctrl.do_del && (idx >= ctrl.mid) &&
                      ((idx + 1'b1) < ctrl.count);

  always_comb begin
    entry_nxt = entry_r;
    if (push_here) begin
      entry_nxt = push_value;
    end else if (shift_here) begin
      entry_nxt = upper_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_value = entry_r;
  assign rd_value    = (ctrl.rd_idx == idx) ? entry_r : '0;

endmodule

// File: hdl/stack_with_middle_access_unit.sv
`timescale 1ns / 1ps
// Top level of the stack with middle access: opcode decode, occupancy
// counter, result register and the row of swm_cell storage cells.
// Depends on swm_pkg and swm_cell.
// Latency: the result of a transaction is on the out_ ports, with out_valid
// high, in the cycle right after start was taken.
// Throughput: one transaction per cycle; busy stays low, since every cell
// updates (including the shift of a middle delete) in the same edge.
// Reset clears the occupancy count and the result strobe; entries keep
// whatever they hold and are only read below the count.
module stack_with_middle_access_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic signed [swm_pkg::DATA_W-1:0]   in_push_value,
  output logic                                out_valid,
  output logic signed [swm_pkg::DATA_W-1:0]   out_result_value,
  output logic [1:0]                          out_status,
  output logic [swm_pkg::OCC_W-1:0]           out_occupancy
);

  swm_pkg::op_t                        op;
  swm_pkg::cell_ctrl_t                 ctrl;
  swm_pkg::status_t                    status_nxt;
  logic [swm_pkg::CNT_W-1:0]           count_r;
  logic [swm_pkg::CNT_W-1:0]           count_nxt;
  logic                                accept;
  logic                                empty;
  logic                                full;
  logic                                do_pop;
  logic signed [swm_pkg::DATA_W-1:0]   rd_data;
  logic signed [swm_pkg::DATA_W-1:0]   result_nxt;
  logic                                out_valid_r;
  logic signed [swm_pkg::DATA_W-1:0]   out_result_r;
  logic [1:0]                          out_status_r;
  logic [swm_pkg::OCC_W-1:0]           out_occ_r;
  logic signed [swm_pkg::DATA_W-1:0]   entry_q [swm_pkg::DEPTH];
  logic signed [swm_pkg::DATA_W-1:0]   rd_q    [swm_pkg::DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = swm_pkg::op_t'(in_opcode);
  assign empty  = (count_r == '0);
  assign full   = (count_r == swm_pkg::CNT_W'(swm_pkg::DEPTH));

  always_comb begin
    ctrl.do_push = 1'b0;
    ctrl.do_del  = 1'b0;
    ctrl.count   = count_r;
    ctrl.mid     = count_r >> 1;
    ctrl.rd_idx  = count_r >> 1;
    do_pop       = 1'b0;
    count_nxt    = count_r;
    status_nxt   = swm_pkg::ST_OK;
    unique case (op)
      swm_pkg::OP_PUSH: begin
        if (full) begin
          status_nxt = swm_pkg::ST_FULL;
        end else begin
          ctrl.do_push = accept;
          count_nxt    = count_r + 1'b1;
        end
      end
      swm_pkg::OP_POP: begin
        ctrl.rd_idx = count_r - 1'b1;
        if (empty) begin
          status_nxt = swm_pkg::ST_EMPTY;
        end else begin
          do_pop    = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      swm_pkg::OP_MID: begin
        if (empty) begin
          status_nxt = swm_pkg::ST_EMPTY;
        end
      end
      swm_pkg::OP_DEL: begin
        if (empty) begin
          status_nxt = swm_pkg::ST_EMPTY;
        end else begin
          ctrl.do_del = accept;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = swm_pkg::ST_OK;
      end
    endcase
  end

  // Only the selected cell drives a nonzero read value.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < swm_pkg::DEPTH; i++) begin
      rd_data = rd_data | rd_q[i];
    end
  end

  assign result_nxt = ((op != swm_pkg::OP_PUSH) && !empty) ? rd_data : '1;

  for (genvar g = 0; g < swm_pkg::DEPTH; g++) begin : g_cell
    logic signed [swm_pkg::DATA_W-1:0] upper;
    if (g < swm_pkg::DEPTH - 1) begin : g_mid
      assign upper = entry_q[g+1];
    end else begin : g_top
      assign upper = '0;
    end
    swm_cell u_cell (
      .clk        (clk),
      .cell_idx   (swm_pkg::IDX_W'(g)),
      .ctrl       (ctrl),
      .push_value (in_push_value),
      .upper_value(upper),
      .entry_value(entry_q[g]),
      .rd_value   (rd_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result_r <= result_nxt;
      out_status_r <= status_nxt;
      out_occ_r    <= swm_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_status       = out_status_r;
  assign out_occupancy    = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= swm_pkg::CNT_W'(swm_pkg::DEPTH))
    else $error("occupancy count exceeds the stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.do_push |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted push did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop || ctrl.do_del) |=> count_r == $past(count_r) - 1'b1)
    else $error("pop or middle delete did not shrink the count");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == swm_pkg::ST_FULL) |->
      out_occupancy == swm_pkg::OCC_W'(swm_pkg::DEPTH))
    else $error("full status reported while the stack was not full");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == swm_pkg::ST_EMPTY) |->
      (out_result_value == -1 && out_occupancy == '0))
    else $error("empty status with a value or nonzero occupancy");

endmodule
